### hdl/url_percent_decoder_assert.svh
// assertion macros for the url percent decoder
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define UPDEC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("url percent decoder: assertion failed");
`define UPDEC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("url percent decoder: assertion failed");
`else
`define UPDEC_ASSERT_NOW(lbl, ante, cons)
`define UPDEC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/updec_pkg.sv
// shared types, constants and helpers of the url percent decoder
package updec_pkg;

    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CHAR_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_F = 8'h66;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_F = 8'h46;
    localparam logic [4:0]        HEX_TEN      = 5'd10;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK  = 2'd0,
        STATUS_BAD = 2'd1,
        STATUS_NUL = 2'd2
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        status_t           status;
    } result_t;

    // bit 4 set when the byte is no hex digit
    function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] b);
        logic [4:0] v;
        v = 5'h10;
        if (b >= CHAR_ZERO && b <= CHAR_NINE)
        begin
            v = 5'(b - CHAR_ZERO);
        end
        else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_F)
        begin
            v = 5'(b - CHAR_LOWER_A) + HEX_TEN;
        end
        else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F)
        begin
            v = 5'(b - CHAR_UPPER_A) + HEX_TEN;
        end
        return v;
    endfunction

endpackage

### hdl/updec_in_if.sv
// input channel of the url percent decoder: encoded bytes
interface updec_in_if;
    logic                         valid;
    logic                         ready;
    logic [updec_pkg::BYTE_W-1:0] in_byte;
    logic                         in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

### hdl/updec_out_if.sv
// output channel of the url percent decoder: decoded bytes and status
interface updec_out_if;
    logic                           valid;
    logic                           ready;
    logic [updec_pkg::BYTE_W-1:0]   out_byte;
    logic                           out_last;
    logic [updec_pkg::STATUS_W-1:0] status;

    modport source (output valid, output out_byte, output out_last, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input status,
                    output ready);
endinterface

### hdl/url_percent_decoder.sv
// url percent decoder: escapes to utf-8, one encoded byte per item
// an accepted item is held in the input register, then written to the result queue
// throughput: one item per cycle while the result queue has room for two results; a
// two-byte escape result gives two output bytes, so the output port sets the sustained rate
// reset: asynchronous active-low rst_n clears the escape state and the result queue
module url_percent_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    updec_in_if.sink    in_stream,
    updec_out_if.source out_stream
);
    import updec_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    // escape state
    phase_t      phase_reg, phase_next;
    logic [3:0]  nib_reg, nib_next;
    logic        discard_reg, discard_next;

    // result queue
    result_t           fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    logic        proceed;
    logic        pop;
    logic [1:0]  push_n;
    result_t     res0, res1;
    logic [4:0]  hv;
    logic [7:0]  val;

    // room for two results before the registered item moves on
    assign proceed = in_valid_reg && (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign in_stream.ready = !in_valid_reg || proceed;
    assign pop = out_stream.valid && out_stream.ready;

    assign hv  = hex_value(byte_reg);
    assign val = {nib_reg, hv[3:0]};

    always_comb
    begin
        phase_next   = phase_reg;
        nib_next     = nib_reg;
        discard_next = discard_reg;
        push_n       = 2'd0;
        res0         = '{data: byte_reg, last: last_reg, status: STATUS_OK};
        res1         = '{data: byte_reg, last: last_reg, status: STATUS_OK};
        if (discard_reg)
        begin
            if (last_reg)
            begin
                discard_next = 1'b0;
                phase_next   = PH_IDLE;
                nib_next     = 4'd0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_FIRST:
                begin
                    if (hv[4] || last_reg)
                    begin
                        phase_next   = PH_IDLE;
                        nib_next     = 4'd0;
                        discard_next = !last_reg;
                        push_n       = 2'd1;
                        res0         = '{data: '0, last: 1'b1, status: STATUS_BAD};
                    end
                    else
                    begin
                        nib_next   = hv[3:0];
                        phase_next = PH_SECOND;
                    end
                end
                PH_SECOND:
                begin
                    phase_next = PH_IDLE;
                    nib_next   = 4'd0;
                    push_n     = 2'd1;
                    if (hv[4] || val == 8'd0)
                    begin
                        discard_next = !last_reg;
                        res0 = '{data: '0, last: 1'b1,
                                 status: hv[4] ? STATUS_BAD : STATUS_NUL};
                    end
                    else if (!val[7])
                    begin
                        res0 = '{data: val, last: last_reg, status: STATUS_OK};
                    end
                    else
                    begin
                        // latin-1 above 0x7f widens to a two-byte utf-8 sequence
                        push_n = 2'd2;
                        res0 = '{data: {6'b110000, val[7:6]}, last: 1'b0,
                                 status: STATUS_OK};
                        res1 = '{data: {2'b10, val[5:0]}, last: last_reg,
                                 status: STATUS_OK};
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (byte_reg == CHAR_PERCENT)
                    begin
                        if (last_reg)
                        begin
                            nib_next     = 4'd0;
                            discard_next = 1'b0;
                            push_n       = 2'd1;
                            res0 = '{data: '0, last: 1'b1, status: STATUS_BAD};
                        end
                        else
                        begin
                            phase_next = PH_FIRST;
                        end
                    end
                    else
                    begin
                        push_n = 2'd1;
                    end
                end
            endcase
        end
    end

    // control and escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
            nib_reg      <= 4'd0;
            discard_reg  <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (in_stream.ready)
            begin
                in_valid_reg <= in_stream.valid;
            end
            if (proceed)
            begin
                phase_reg   <= phase_next;
                nib_reg     <= nib_next;
                discard_reg <= discard_next;
                wr_ptr_reg  <= wr_ptr_reg + PTR_W'(push_n);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + (proceed ? CNT_W'(push_n) : CNT_W'(0))
                         - (pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_stream.valid && in_stream.ready)
        begin
            byte_reg <= in_stream.in_byte;
            last_reg <= in_stream.in_last;
        end
        if (proceed && push_n != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (proceed && push_n == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    assign out_stream.valid    = (count_reg != '0);
    assign out_stream.out_byte = fifo_reg[rd_ptr_reg].data;
    assign out_stream.out_last = fifo_reg[rd_ptr_reg].last;
    assign out_stream.status   = fifo_reg[rd_ptr_reg].status;

`include "url_percent_decoder_assert.svh"

    `UPDEC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH))
    `UPDEC_ASSERT_NOW(a_discard_silent, proceed && discard_reg, push_n == 2'd0)
    `UPDEC_ASSERT_NOW(a_error_result,
        proceed && push_n != 2'd0 && res0.status != STATUS_OK,
        res0.last && res0.data == '0 && push_n == 2'd1)
    `UPDEC_ASSERT_NEXT(a_last_clears, proceed && last_reg,
        phase_reg == PH_IDLE && !discard_reg && nib_reg == 4'd0)

endmodule

### sim/url_percent_decoder_checker.sv
// scoreboard for the url percent decoder: predicts the decoded bytes and checks every result
`timescale 1ns / 1ps
module url_percent_decoder_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [updec_pkg::BYTE_W-1:0]   in_byte,
    input  logic                           in_last,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [updec_pkg::BYTE_W-1:0]   out_byte,
    input  logic                           out_last,
    input  logic [updec_pkg::STATUS_W-1:0] out_status,
    output int                             mismatches,
    output int                             outstanding
);
    import updec_pkg::*;

    localparam logic [1:0] PH_PLAIN  = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    logic [1:0] esc_phase = PH_PLAIN;
    logic [3:0] hi_nib    = 4'h0;
    logic       dropping  = 1'b0;
    result_t    decoded_q[$];
    result_t    head;

    // bit 4 flags a byte that is not a hex digit
    function automatic logic [4:0] digit_value(input logic [BYTE_W-1:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            return {1'b0, c[3:0]};
        end
        if ((c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) ||
            (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F))
        begin
            return {1'b0, c[3:0] + 4'd9};
        end
        return 5'h10;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic expect_byte(input logic [BYTE_W-1:0] d, input logic l, input status_t st);
        decoded_q.push_back('{data: d, last: l, status: st});
    endtask

    task automatic abort_string(input logic l, input status_t st);
        esc_phase = PH_PLAIN;
        hi_nib    = 4'h0;
        dropping  = !l;
        expect_byte('0, 1'b1, st);
    endtask

    task automatic decode_item(input logic [BYTE_W-1:0] c, input logic l);
        logic [4:0]        dv;
        logic [BYTE_W-1:0] code;
        dv = digit_value(c);
        if (dropping)
        begin
            if (l)
            begin
                dropping  = 1'b0;
                esc_phase = PH_PLAIN;
                hi_nib    = 4'h0;
            end
        end
        else if (esc_phase == PH_FIRST)
        begin
            // a string may not end on the first digit either
            if (dv[4] || l)
                abort_string(l, STATUS_BAD);
            else
            begin
                hi_nib    = dv[3:0];
                esc_phase = PH_SECOND;
            end
        end
        else if (esc_phase == PH_SECOND)
        begin
            if (dv[4])
                abort_string(l, STATUS_BAD);
            else
            begin
                code      = {hi_nib, dv[3:0]};
                esc_phase = PH_PLAIN;
                hi_nib    = 4'h0;
                if (code == '0)
                    abort_string(l, STATUS_NUL);
                else if (!code[7])
                    expect_byte(code, l, STATUS_OK);
                else
                begin
                    // latin-1 above 0x7f widens to a two-byte utf-8 sequence
                    expect_byte({6'b110000, code[7:6]}, 1'b0, STATUS_OK);
                    expect_byte({2'b10, code[5:0]}, l, STATUS_OK);
                end
            end
        end
        else
        begin
            esc_phase = PH_PLAIN;
            if (c == CHAR_PERCENT)
            begin
                if (l)
                    abort_string(l, STATUS_BAD);
                else
                    esc_phase = PH_FIRST;
            end
            else
                expect_byte(c, l, STATUS_OK);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_phase = PH_PLAIN;
            hi_nib    = 4'h0;
            dropping  = 1'b0;
            decoded_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                    report_mismatch($sformatf("result %02h last %0b status %0d, none expected",
                                              out_byte, out_last, out_status));
                else
                begin
                    head = decoded_q.pop_front();
                    if (out_byte !== head.data)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  out_byte, head.data));
                    if (out_last !== head.last)
                        report_mismatch($sformatf("out_last %0b, expected %0b",
                                                  out_last, head.last));
                    if (out_status !== head.status)
                        report_mismatch($sformatf("status %0d, expected %s",
                                                  out_status, head.status.name()));
                end
            end
            if (in_valid && in_ready)
                decode_item(in_byte, in_last);
        end
        outstanding = decoded_q.size();
    end

endmodule

### sim/testbench.sv
// top of the url percent decoder testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
    import updec_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 212;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    idle_mode_t mode  = IDLE_NONE;
    int         items_sent;
    int         cycle_count;
    int         mismatches;
    int         outstanding;

    updec_in_if  in_ch();
    updec_out_if out_ch();

    url_percent_decoder dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_ch),
        .out_stream (out_ch)
    );

    url_percent_decoder_checker chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .in_byte     (in_ch.in_byte),
        .in_last     (in_ch.in_last),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_byte    (out_ch.out_byte),
        .out_last    (out_ch.out_last),
        .out_status  (out_ch.status),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (mode == IDLE_SNK)
            out_ch.ready <= ($urandom_range(0, 99) >= 68);
        else if (mode == IDLE_BOTH)
            out_ch.ready <= ($urandom_range(0, 99) >= 33);
        else
            out_ch.ready <= 1'b1;
    end

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return CHAR_ZERO + 8'(nib);
        return ($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(nib - 4'd10);
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= CHAR_ZERO && c <= CHAR_NINE) ||
               (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) ||
               (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F));
        return c;
    endfunction

    task automatic send_item(input logic [7:0] c, input logic l);
        @(negedge clk);
        while ((mode == IDLE_SRC && $urandom_range(0, 99) < 68) ||
               (mode == IDLE_BOTH && $urandom_range(0, 99) < 33))
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= c;
        in_ch.in_last <= l;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], i == s.len() - 1);
    endtask

    // mostly well-formed escapes and plain bytes, with some broken escapes mixed in
    task automatic send_random_string();
        logic [7:0] chars[$];
        logic [7:0] v;
        int         n;
        int         kind;
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++)
        begin
            kind = $urandom_range(0, 99);
            v    = 8'($urandom_range(0, 255));
            if (kind < 50)
                chars.push_back(v);
            else if (kind < 88)
            begin
                chars.push_back(CHAR_PERCENT);
                chars.push_back(hex_char(v[7:4]));
                chars.push_back(hex_char(v[3:0]));
            end
            else if (kind < 93)
            begin
                chars.push_back(CHAR_PERCENT);
                chars.push_back(hex_char(v[7:4]));
                chars.push_back(junk_char());
            end
            else if (kind < 96)
            begin
                chars.push_back(CHAR_PERCENT);
                chars.push_back(junk_char());
            end
            else if (kind < 98)
            begin
                chars.push_back(CHAR_PERCENT);
                chars.push_back(CHAR_ZERO);
                chars.push_back(CHAR_ZERO);
            end
            else
                chars.push_back(CHAR_PERCENT);
        end
        foreach (chars[i])
            send_item(chars[i], i == chars.size() - 1);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        in_ch.in_last = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // plain extremes, both hex cases, wide escapes, then each way an escape can fail
        send_item(8'h00, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hFF, 1'b1);
        send_text("%41%Ff%e9");
        send_text("%00Z");
        send_text("%g%");
        send_text("%4z");
        send_text("%");
        send_text("%4");

        for (int p = IDLE_NONE; p <= IDLE_BOTH; p++)
        begin
            mode = idle_mode_t'(p);
            items_sent = 0;
            while (items_sent < ITEMS_PER_PHASE)
                send_random_string();
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/updec_pkg.sv
hdl/updec_in_if.sv
hdl/updec_out_if.sv
hdl/url_percent_decoder.sv
sim/url_percent_decoder_checker.sv
sim/testbench.sv
